// ===== hdl/sbr_pkg.sv =====
// ----------------------------------------------------------------------------
// sbr_pkg
// Shared word types, field widths and sequencer states of the stream byte
// reassembler.
// ----------------------------------------------------------------------------
`default_nettype none

package sbr_pkg;

    localparam int IDX_W  = 32;
    localparam int BYTE_W = 8;
    localparam int PEND_W = 7;

    // One input word: a segment byte at its stream index, or an end marker.
    typedef struct packed {
        logic [IDX_W-1:0]  stream_index;
        logic              has_byte;
        logic [BYTE_W-1:0] in_byte;
        logic              stream_ends;
    } t_in_word;

    // One result word.
    typedef struct packed {
        logic              out_valid;
        logic [BYTE_W-1:0] out_byte;
        logic              stream_done;
        logic              last_of_run;
        logic [PEND_W-1:0] pending_bytes;
    } t_out_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_END,
        ST_STORE,
        ST_CHECK,
        ST_LOOK,
        ST_EMIT
    } t_state;

endpackage

`default_nettype wire

// ===== hdl/stream_byte_reassembler_core.sv =====
// ----------------------------------------------------------------------------
// stream_byte_reassembler_core
// Rebuilds an in-order byte stream from bytes that arrive out of order. Bytes
// inside the window of CAPACITY positions from the next expected index are
// parked in a ring, and every byte that becomes contiguous is delivered.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                 Direction  Handshake
//  --------  ----------------------  ---------  ------------------------------
//  input     start, busy, i_item     in         word taken when start && !busy
//  result    strobe, o_result        out        one cycle per word, no stall
//
// An input word keeps the block busy while it passes through the end update,
// the store and the done check, and then through a look-up and a delivery
// step for each released byte; a delivery follows its look-up because it
// waits on the registered read port of the ring. The last delivery returns
// straight to idle, while a look-up that finds nothing ends the run with a
// status word. Each word yields at least one result.
// Reset clears the valid map in flip-flops at once, so no clearing pass is
// needed. The result side cannot stall: each result word is shown for
// exactly one cycle with strobe high.
// ----------------------------------------------------------------------------
`default_nettype none

module stream_byte_reassembler_core #(
    parameter int CAPACITY = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire sbr_pkg::t_in_word i_item,
    output logic                   strobe,
    output sbr_pkg::t_out_word     o_result
);

    // Slot index width and pending-count width follow from the ring depth.
    localparam int SW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = sbr_pkg::IDX_W;
    localparam int PW = sbr_pkg::PEND_W;

    // Sequencer and architectural state.
    sbr_pkg::t_state    r_state, n_state;
    sbr_pkg::t_in_word  r_item;
    logic [IW-1:0]      r_next, n_next;
    logic [IW-1:0]      r_end, n_end;
    logic               r_end_known, n_end_known;
    logic [CW-1:0]      r_pending, n_pending;
    logic               r_finished, n_finished;
    logic [CAPACITY-1:0] r_valid, n_valid;
    logic [SW-1:0]      r_head, n_head;
    logic               r_strobe, n_strobe;
    sbr_pkg::t_out_word r_result, n_result;

    // The shared comparator. In the store step it checks the byte index
    // against the end index; in the done check and in each delivery step it
    // checks the next expected index against the end index.
    logic [IW-1:0] cmp_a;
    logic          cmp_ge;
    logic          done_hit;

    assign cmp_a    = (r_state == sbr_pkg::ST_STORE) ? r_item.stream_index : r_next;
    assign cmp_ge   = cmp_a >= r_end;
    assign done_hit = r_end_known && cmp_ge;

    // Window test and ring slot of the incoming byte. The slot is found from
    // the head slot plus the offset into the window, which is below CAPACITY,
    // so one conditional subtract folds it back into the ring.
    logic [IW:0]   diff_ext;
    logic          in_window;
    logic [SW:0]   slot_sum;
    logic [SW-1:0] in_slot;
    logic          store_ok;

    assign diff_ext  = {1'b0, r_item.stream_index} - {1'b0, r_next};
    assign in_window = !diff_ext[IW] && (diff_ext[IW-1:0] < IW'(CAPACITY));
    assign slot_sum  = {1'b0, r_head} + {1'b0, diff_ext[SW-1:0]};
    assign in_slot   = (slot_sum >= (SW+1)'(CAPACITY))
                     ? SW'(slot_sum - (SW+1)'(CAPACITY)) : slot_sum[SW-1:0];
    assign store_ok  = r_item.has_byte && !r_finished && in_window
                     && !done_hit && !r_valid[in_slot];

    logic [SW-1:0] head_inc;
    assign head_inc = (r_head == SW'(CAPACITY - 1)) ? '0 : r_head + SW'(1);

    // A delivery ends the run when it finishes the stream or when the slot
    // at the new head holds nothing.
    logic emit_last;
    assign emit_last = done_hit || !r_valid[r_head];

    logic                       ring_we, ring_re;
    logic [sbr_pkg::BYTE_W-1:0] ring_rdata;

    sbr_ring #(
        .DEPTH (CAPACITY),
        .AW    (SW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (in_slot),
        .i_wdata (r_item.in_byte),
        .i_re    (ring_re),
        .i_raddr (r_head),
        .o_rdata (ring_rdata)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            sbr_pkg::ST_IDLE: begin
                if (start) begin
                    n_state = sbr_pkg::ST_END;
                end
            end
            sbr_pkg::ST_END:   n_state = sbr_pkg::ST_STORE;
            sbr_pkg::ST_STORE: n_state = sbr_pkg::ST_CHECK;
            sbr_pkg::ST_CHECK: n_state = sbr_pkg::ST_LOOK;
            sbr_pkg::ST_LOOK: begin
                if (!r_finished && r_valid[r_head]) begin
                    n_state = sbr_pkg::ST_EMIT;
                end else begin
                    n_state = sbr_pkg::ST_IDLE;
                end
            end
            sbr_pkg::ST_EMIT: begin
                if (emit_last) begin
                    n_state = sbr_pkg::ST_IDLE;
                end else begin
                    n_state = sbr_pkg::ST_LOOK;
                end
            end
            default: n_state = sbr_pkg::ST_IDLE;
        endcase
    end

    // Datapath updates and result words.
    always_comb begin
        n_next      = r_next;
        n_end       = r_end;
        n_end_known = r_end_known;
        n_pending   = r_pending;
        n_finished  = r_finished;
        n_valid     = r_valid;
        n_head      = r_head;
        n_strobe    = 1'b0;
        n_result    = r_result;
        ring_we     = 1'b0;
        ring_re     = 1'b0;
        case (r_state)
            sbr_pkg::ST_END: begin
                // An end flag always rewrites the end index, even when the
                // byte itself is later dropped.
                if (r_item.stream_ends) begin
                    n_end       = r_item.has_byte ? r_item.stream_index + IW'(1)
                                                  : r_item.stream_index;
                    n_end_known = 1'b1;
                end
            end
            sbr_pkg::ST_STORE: begin
                if (store_ok) begin
                    ring_we          = 1'b1;
                    n_valid[in_slot] = 1'b1;
                    n_pending        = r_pending + CW'(1);
                end
            end
            sbr_pkg::ST_CHECK: begin
                if (done_hit) begin
                    n_finished = 1'b1;
                end
            end
            sbr_pkg::ST_LOOK: begin
                if (!r_finished && r_valid[r_head]) begin
                    ring_re         = 1'b1;
                    n_valid[r_head] = 1'b0;
                    if (r_pending != '0) begin
                        n_pending = r_pending - CW'(1);
                    end
                    n_next = r_next + IW'(1);
                    n_head = head_inc;
                end else begin
                    // Nothing was released: a status-only word ends the run.
                    n_strobe               = 1'b1;
                    n_result.out_valid     = 1'b0;
                    n_result.out_byte      = '0;
                    n_result.stream_done   = r_finished;
                    n_result.last_of_run   = 1'b1;
                    n_result.pending_bytes = PW'(r_pending);
                end
            end
            sbr_pkg::ST_EMIT: begin
                if (done_hit) begin
                    n_finished = 1'b1;
                end
                n_strobe               = 1'b1;
                n_result.out_valid     = 1'b1;
                n_result.out_byte      = ring_rdata;
                n_result.stream_done   = r_finished || done_hit;
                n_result.last_of_run   = emit_last;
                n_result.pending_bytes = PW'(r_pending);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sbr_pkg::ST_IDLE;
            r_next      <= '0;
            r_end       <= '0;
            r_end_known <= 1'b0;
            r_pending   <= '0;
            r_finished  <= 1'b0;
            r_valid     <= '0;
            r_head      <= '0;
            r_strobe    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_next      <= n_next;
            r_end       <= n_end;
            r_end_known <= n_end_known;
            r_pending   <= n_pending;
            r_finished  <= n_finished;
            r_valid     <= n_valid;
            r_head      <= n_head;
            r_strobe    <= n_strobe;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        if (start && !busy) begin
            r_item <= i_item;
        end
    end

    assign busy     = (r_state != sbr_pkg::ST_IDLE);
    assign strobe   = r_strobe;
    assign o_result = r_result;

`ifndef NO_ASSERTIONS
    // The pending count always matches the number of parked bytes.
    a_pending_matches_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_pending))
        else $error("pending count differs from valid map");

    // Once the stream is finished it stays finished.
    a_finished_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_finished |=> r_finished)
        else $error("finished flag dropped");

    // A status-only word always closes its run.
    a_status_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (strobe && !o_result.out_valid) |-> o_result.last_of_run)
        else $error("status word not marked last");

    // No result word follows directly after an input word is taken.
    a_no_strobe_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !strobe)
        else $error("result shown right after accept");
`endif

endmodule

`default_nettype wire

// ===== hdl/sbr_ring.sv =====
// ----------------------------------------------------------------------------
// sbr_ring
// Byte ring storage: one write port and one read port with registered
// read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sbr_ring #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_we,
    input  wire logic [AW-1:0]             i_waddr,
    input  wire logic [sbr_pkg::BYTE_W-1:0] i_wdata,
    input  wire logic                      i_re,
    input  wire logic [AW-1:0]             i_raddr,
    output logic      [sbr_pkg::BYTE_W-1:0] o_rdata
);

    logic [sbr_pkg::BYTE_W-1:0] r_mem [DEPTH];
    logic [sbr_pkg::BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire
